[rtl/xs1024s_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xs1024s_pkg
// Shared constants and mixing functions of the xorshift1024* generator.
// ----------------------------------------------------------------------------
package xs1024s_pkg;

    localparam int RING_DEPTH = 16;
    localparam int RING_AW    = 4;
    localparam int WORD_W     = 64;

    localparam logic [63:0] FMIX_MUL_A = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] FMIX_MUL_B = 64'hc4ce_b9fe_1a85_ec53;
    localparam logic [63:0] XS64_MUL   = 64'd2685821657736338717;
    localparam logic [63:0] XS1024_MUL = 64'd1181783497276652981;

    // Operation codes carried in tuser
    localparam logic OP_NEXT = 1'b0;
    localparam logic OP_SEED = 1'b1;

    // Finalizer shift-xor step
    function automatic logic [63:0] fmix_xor(input logic [63:0] v);
        fmix_xor = v ^ (v >> 33);
    endfunction

    // xorshift64* shift stage ahead of its multiply
    function automatic logic [63:0] xs64_pre(input logic [63:0] v);
        logic [63:0] t;
        t = v ^ (v >> 12);
        t = t ^ (t << 25);
        t = t ^ (t >> 27);
        xs64_pre = t;
    endfunction

    // xorshift1024 combine of the old word a and the new word b
    function automatic logic [63:0] xs1024_mix(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] tb;
        tb = b ^ (b << 31);
        tb = tb ^ (tb >> 11);
        xs1024_mix = (a ^ (a >> 30)) ^ tb;
    endfunction

endpackage
`default_nettype wire

[rtl/xorshift1024_star_generator.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xorshift1024_star_generator
// xorshift1024* generator with a RAM-held state ring and a shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: s_tuser selects the operation (0 = next word, 1 = reseed),
//   s_tdata carries the seed. A reseed transaction gives no result.
//   Master channel: m_tdata carries one 64-bit random word per next request.
//   A next request passes through the ring RAM read, the write-back of the
//   mix and the multiply (one 32 x 32 partial product per cycle) before its
//   word is loaded into the output register; the block takes a new
//   transaction only once that word has reached the output register.
//   A reseed runs 20 multiplies, during which s_tready is low; the ring is
//   refilled word 0 first.
//   Reset: ring words read as zero through per-entry valid flags, position
//   zero, no result pending. The generator outputs zero until reseeded.
//   Stall: a finished word waits in the output register until m_tready; a
//   new transaction is still accepted meanwhile, and a second word waits in
//   the multiplier until the output register frees.
// ----------------------------------------------------------------------------
module xorshift1024_star_generator
    import xs1024s_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [63:0] seed_value
    input  wire logic        s_tuser,   // [0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata    // [63:0] random_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX,
        ST_NEXT_MUL,
        ST_FINISH,
        ST_FMIX,
        ST_FILL
    } state_t;

    state_t                 state_reg;
    logic [RING_AW-1:0]     pos_reg;
    logic [RING_AW-1:0]     fill_reg;
    logic [1:0]             phase_reg;
    logic [RING_DEPTH-1:0]  valid_reg;
    logic [WORD_W-1:0]      cur_reg;
    logic                   start_reg;
    logic [WORD_W-1:0]      mul_a_reg;
    logic [WORD_W-1:0]      mul_b_reg;
    logic                   m_tvalid_reg;
    logic [WORD_W-1:0]      m_tdata_reg;

    logic                   ram_we;
    logic [RING_AW-1:0]     ram_waddr;
    logic [WORD_W-1:0]      ram_wdata;
    logic [RING_AW-1:0]     ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;

    logic                   mul_done;
    logic [WORD_W-1:0]      mul_product;

    logic [RING_AW-1:0]     new_pos;
    logic [WORD_W-1:0]      new_word;
    logic [WORD_W-1:0]      mix_word;
    logic [WORD_W-1:0]      fmix_prod;
    logic [1:0]             phase_next;
    logic                   out_free;
    logic                   out_load;

    assign new_pos   = pos_reg + 1'b1;
    assign ram_raddr = new_pos;
    assign new_word  = valid_reg[new_pos] ? ram_rdata : '0;
    assign mix_word  = xs1024_mix(cur_reg, new_word);
    assign fmix_prod = fmix_xor(mul_product);
    assign phase_next = phase_reg + 2'd1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign out_load  = out_free &&
                       ((state_reg == ST_NEXT_MUL && mul_done) || state_reg == ST_FINISH);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = new_pos;
        ram_wdata = mix_word;
        if (state_reg == ST_MIX) begin
            ram_we = 1'b1;
        end else if (state_reg == ST_FILL && mul_done) begin
            ram_we    = 1'b1;
            ram_waddr = fill_reg;
            ram_wdata = mul_product;
        end
    end

    xs1024s_ram #(
        .WIDTH(WORD_W),
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    xs1024s_mul u_mul (
        .aclk   (aclk),
        .aresetn(aresetn),
        .start  (start_reg),
        .op_a   (mul_a_reg),
        .op_b   (mul_b_reg),
        .done   (mul_done),
        .product(mul_product)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            fill_reg     <= '0;
            phase_reg    <= 2'd0;
            valid_reg    <= '0;
            cur_reg      <= '0;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // load a finished word, or drop the one just taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= mul_product;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid && s_tuser == OP_SEED) begin
                        start_reg <= 1'b1;
                        mul_a_reg <= fmix_xor(s_tdata);
                        mul_b_reg <= FMIX_MUL_A;
                        phase_reg <= 2'd0;
                        state_reg <= ST_FMIX;
                    end else begin
                        start_reg <= 1'b0;
                        if (s_tvalid) begin
                            state_reg <= ST_MIX;
                        end
                    end
                end
                ST_MIX: begin
                    // write back the mix, keep it as the word at the position
                    valid_reg[new_pos] <= 1'b1;
                    cur_reg            <= mix_word;
                    pos_reg            <= new_pos;
                    start_reg          <= 1'b1;
                    mul_a_reg          <= mix_word;
                    mul_b_reg          <= XS1024_MUL;
                    state_reg          <= ST_NEXT_MUL;
                end
                ST_NEXT_MUL: begin
                    start_reg <= 1'b0;
                    if (mul_done) begin
                        state_reg <= out_free ? ST_IDLE : ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    // hold the product until the output register frees
                    start_reg <= 1'b0;
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FMIX: begin
                    start_reg <= mul_done;
                    if (mul_done) begin
                        if (phase_reg == 2'd3) begin
                            mul_a_reg <= xs64_pre(fmix_prod);
                            mul_b_reg <= XS64_MUL;
                            fill_reg  <= '0;
                            state_reg <= ST_FILL;
                        end else begin
                            phase_reg <= phase_next;
                            // second round opens right after the first one's closing xor
                            mul_a_reg <= (phase_next == 2'd2) ? fmix_xor(fmix_prod) : fmix_prod;
                            mul_b_reg <= phase_next[0] ? FMIX_MUL_B : FMIX_MUL_A;
                        end
                    end
                end
                ST_FILL: begin
                    start_reg <= mul_done && (fill_reg != RING_AW'(RING_DEPTH - 1));
                    if (mul_done) begin
                        valid_reg[fill_reg] <= 1'b1;
                        if (fill_reg == pos_reg) begin
                            cur_reg <= mul_product;
                        end
                        if (fill_reg == RING_AW'(RING_DEPTH - 1)) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            fill_reg  <= fill_reg + 1'b1;
                            mul_a_reg <= xs64_pre(mul_product);
                            mul_b_reg <= XS64_MUL;
                        end
                    end
                end
                default: begin
                    start_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

[rtl/xs1024s_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xs1024s_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module xs1024s_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/xs1024s_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// xs1024s_mul
// Low 64 bits of a 64 x 64 product, one 32 x 32 partial product per cycle.
// ----------------------------------------------------------------------------
module xs1024s_mul
    import xs1024s_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] op_a,
    input  wire logic [63:0] op_b,
    output logic             done,
    output logic [63:0]      product
);

    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] acc_reg;
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] pp;

    // lo*lo, then lo*hi and hi*lo folded into the upper half
    always_comb begin
        case (step_reg)
            2'd0:    begin mx = a_reg[31:0];  my = b_reg[31:0];  end
            2'd1:    begin mx = a_reg[31:0];  my = b_reg[63:32]; end
            2'd2:    begin mx = a_reg[63:32]; my = b_reg[31:0];  end
            default: begin mx = a_reg[31:0];  my = b_reg[31:0];  end
        endcase
    end

    assign pp = mx * my;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 2'd0;
        end else begin
            done_reg <= !start && busy_reg && (step_reg == 2'd2);
            if (start) begin
                a_reg    <= op_a;
                b_reg    <= op_b;
                step_reg <= 2'd0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (step_reg == 2'd0) begin
                    acc_reg <= pp;
                end else begin
                    acc_reg <= {acc_reg[63:32] + pp[31:0], acc_reg[31:0]};
                end
                if (step_reg == 2'd2) begin
                    busy_reg <= 1'b0;
                end
                step_reg <= step_reg + 2'd1;
            end
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

[dv/xorshift1024_star_generator_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xorshift1024_star_generator_tb
// Streams next-word and reseed requests into the generator under changing
// source gaps and sink back-pressure, including one long sink hold-off.
// A local copy of the sixteen-word ring predicts every random word, and each
// word received is compared in order against the predicted words.
// ----------------------------------------------------------------------------
module xorshift1024_star_generator_tb;
    import xs1024s_pkg::*;

    localparam logic [63:0] K_FMIX_A  = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] K_FMIX_B  = 64'hc4ce_b9fe_1a85_ec53;
    localparam logic [63:0] K_XS64    = 64'd2685821657736338717;
    localparam logic [63:0] K_XS1024  = 64'd1181783497276652981;
    localparam int          HOLD_LEN  = 400;
    localparam int          TAIL_CYC  = 120;

    typedef struct packed {
        logic        op;
        logic [63:0] seed;
    } gen_req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    wire logic   s_tready;
    logic [63:0] s_tdata = '0;      // [63:0] seed_value
    logic        s_tuser = OP_NEXT; // [0] op
    wire logic   m_tvalid;
    logic        m_tready = 1'b0;
    wire logic [63:0] m_tdata;      // [63:0] random_word

    gen_req_t    req_queue[$];
    logic [63:0] due_words[$];
    logic [63:0] ring_q[16];
    logic [3:0]  ring_pos;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        pressure_on = 1'b0;
    logic        pressure_done;
    int          hold_left;
    int          err_count = 0;

    xorshift1024_star_generator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        err_count++;
    endtask

    // MurmurHash3 64-bit finalizer
    function automatic logic [63:0] fmix64(input logic [63:0] v);
        logic [63:0] t;
        t = v ^ (v >> 33);
        t = t * K_FMIX_A;
        t = t ^ (t >> 33);
        t = t * K_FMIX_B;
        return t ^ (t >> 33);
    endfunction

    task automatic refill_ring(input logic [63:0] seed);
        logic [63:0] st;
        st = fmix64(fmix64(seed));
        for (int i = 0; i < 16; i++) begin
            st = st ^ (st >> 12);
            st = st ^ (st << 25);
            st = st ^ (st >> 27);
            st = st * K_XS64;
            ring_q[i] = st;
        end
    endtask

    task automatic advance_ring(output logic [63:0] word);
        logic [3:0]  np;
        logic [63:0] a;
        logic [63:0] b;
        np = ring_pos + 4'd1;
        a = ring_q[ring_pos];
        b = ring_q[np];
        b = b ^ (b << 31);
        b = b ^ (b >> 11);
        a = a ^ (a >> 30);
        ring_q[np] = a ^ b;
        ring_pos = np;
        word = ring_q[np] * K_XS1024;
    endtask

    task automatic push_req(input logic op, input logic [63:0] seed);
        gen_req_t r;
        r.op = op;
        r.seed = seed;
        req_queue.push_back(r);
    endtask

    // Mostly next requests with the odd reseed in between; seeds are sometimes zero.
    task automatic push_random(input int n, input int unsigned seed_pct);
        logic [63:0] v;
        for (int i = 0; i < n; i++) begin
            v = {$urandom, $urandom};
            if ($urandom_range(99) < seed_pct) begin
                if ($urandom_range(15) == 0)
                    v = '0;
                push_req(OP_SEED, v);
            end else begin
                push_req(OP_NEXT, v);
            end
        end
    endtask

    task automatic drain;
        while (req_queue.size() != 0 || s_tvalid || due_words.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Source side
    always @(posedge aclk) begin
        gen_req_t r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                r = req_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= r.op;
                s_tdata  <= r.seed;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Sink ready, with one long hold-off when pressure is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
            pressure_done <= 1'b0;
        end else if (pressure_on && !pressure_done) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_LEN;
            pressure_done <= 1'b1;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Predict on each accepted request, check on each accepted word
    always @(posedge aclk) begin
        logic [63:0] w;
        if (!aresetn) begin
            for (int i = 0; i < 16; i++)
                ring_q[i] = '0;
            ring_pos = '0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tuser == OP_SEED) begin
                    refill_ring(s_tdata);
                end else begin
                    advance_ring(w);
                    due_words.push_back(w);
                end
            end
            if (m_tvalid && m_tready) begin
                if (due_words.size() == 0)
                    report_mismatch("unexpected word", m_tdata, '0);
                else begin
                    w = due_words.pop_front();
                    if (m_tdata !== w)
                        report_mismatch("random_word", m_tdata, w);
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Zero ring after reset, zero seed, extreme and sparse seeds, back-to-back reseeds
        push_req(OP_NEXT, '1);
        push_req(OP_NEXT, '0);
        push_req(OP_SEED, '0);
        push_req(OP_NEXT, '1);
        push_req(OP_NEXT, '0);
        push_req(OP_SEED, '1);
        push_req(OP_NEXT, '0);
        push_req(OP_NEXT, '1);
        push_req(OP_NEXT, '0);
        push_req(OP_SEED, 64'h1);
        push_req(OP_NEXT, '0);
        push_req(OP_SEED, 64'h8000_0000_0000_0000);
        push_req(OP_NEXT, '0);
        push_req(OP_SEED, 64'h5555_5555_5555_5555);
        push_req(OP_SEED, 64'haaaa_aaaa_aaaa_aaaa);
        push_req(OP_NEXT, '1);
        push_req(OP_NEXT, '0);
        push_req(OP_NEXT, '1);
        push_req(OP_NEXT, '0);
        push_req(OP_SEED, 64'h0123_4567_89ab_cdef);
        push_req(OP_NEXT, '0);
        push_req(OP_NEXT, '1);
        push_req(OP_NEXT, '0);
        push_req(OP_NEXT, '1);
        drain();

        push_random(400, 4);
        drain();

        send_idle_pct = 59;
        push_random(400, 4);
        drain();

        send_idle_pct = 0;
        recv_stall_pct = 59;
        push_random(400, 4);
        drain();

        send_idle_pct = 21;
        recv_stall_pct = 21;
        push_random(400, 4);
        drain();

        // Hold the sink off while the source keeps offering next requests
        send_idle_pct = 0;
        recv_stall_pct = 0;
        pressure_on = 1'b1;
        push_random(230, 2);
        drain();

        repeat (TAIL_CYC) @(posedge aclk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
